// ----- rtl/core/bvle_pkg.sv -----
package bvle_pkg;

    localparam int CAPACITY = 64;
    localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam int OP_W     = 2;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int HELD_W   = 7;

    // request kinds
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

    // response status codes
    localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

    localparam logic signed [VALUE_W-1:0] NEG_ONE = -32'sd1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN,
        S_MOVE,
        S_DONE
    } state_t;

    // one cycle of traffic to the entry store
    typedef struct packed {
        logic                      wr_en;
        logic [ADDR_W-1:0]         wr_addr;
        logic signed [VALUE_W-1:0] wr_data;
        logic                      rd_en;
        logic [ADDR_W-1:0]         rd_addr;
    } store_cmd_t;

endpackage

// ----- rtl/core/bvle_req_if.sv -----
interface bvle_req_if;
    logic                               valid;
    logic                               ready;
    logic [bvle_pkg::OP_W-1:0]          op;
    logic signed [bvle_pkg::VALUE_W-1:0] value;

    modport source (output valid, output op, output value, input ready);
    modport sink   (input valid, input op, input value, output ready);
endinterface

// ----- rtl/core/bvle_rsp_if.sv -----
interface bvle_rsp_if;
    logic                                valid;
    logic                                ready;
    logic [bvle_pkg::STATUS_W-1:0]       status;
    logic signed [bvle_pkg::VALUE_W-1:0] result_value;
    logic [bvle_pkg::HELD_W-1:0]         entries_held;

    modport source (output valid, output status, output result_value,
                    output entries_held, input ready);
    modport sink   (input valid, input status, input result_value,
                    input entries_held, output ready);
endinterface

// ----- rtl/core/bvle_store.sv -----
module bvle_store (
    input  logic                                clk,
    input  bvle_pkg::store_cmd_t                cmd,
    input  logic signed [bvle_pkg::VALUE_W-1:0] cmp_value,
    output logic signed [bvle_pkg::VALUE_W-1:0] rd_data,
    output logic                                match
);

    logic signed [bvle_pkg::VALUE_W-1:0] mem [bvle_pkg::CAPACITY];
    logic signed [bvle_pkg::VALUE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[cmd.wr_addr] <= cmd.wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[cmd.rd_addr];
        end
    end

    // shared equality compare on the registered read word
    assign rd_data = rd_data_reg;
    assign match   = (rd_data_reg == cmp_value);

endmodule

// ----- rtl/core/bounded_value_list_engine.sv -----
// Bounded value list: holds up to CAPACITY (64) signed 32-bit values and
// serves one request at a time. Insert appends a value (status full when the
// store already holds CAPACITY entries), search reports found / not found,
// delete removes one matching entry and returns it, or returns -1 with
// status empty or not found. Entries are kept packed in a single-port-read
// memory at addresses 0..count-1; a delete fills the hole with the last
// entry. Insert, unused op codes and a delete on an empty store pass from
// the dispatch state straight to the done state. Search and delete
// walk the packed entries through the one read port and shared comparator at
// one entry per cycle. A hit ends the scan at the matching entry, a miss
// only after every held entry; a delete that moves the last entry into the
// hole also passes through a move state. The worst case is a miss over a
// full store. The engine returns to idle before it takes the next request.
// The block takes no new request while one is in flight; the finished
// result sits in an output register, so the next request is taken as soon
// as the engine returns to idle even when the previous result has not been
// collected. No clearing pass: reset clears the fill count, the state and
// the valid flags, not the stored entries.
module bounded_value_list_engine (
    input  logic         clk,
    input  logic         rst_n,
    bvle_req_if.sink     req,
    bvle_rsp_if.source   rsp
);

    bvle_pkg::state_t state_reg, state_next;

    logic [bvle_pkg::OP_W-1:0]           op_reg, op_next;
    logic signed [bvle_pkg::VALUE_W-1:0] value_reg, value_next;
    logic [bvle_pkg::CNT_W-1:0]          count_reg, count_next;
    logic [bvle_pkg::CNT_W-1:0]          idx_reg, idx_next;
    logic                                cmp_vld_reg, cmp_vld_next;
    logic [bvle_pkg::ADDR_W-1:0]         cmp_addr_reg, cmp_addr_next;
    logic [bvle_pkg::ADDR_W-1:0]         hit_addr_reg, hit_addr_next;
    logic [bvle_pkg::STATUS_W-1:0]       res_status_reg, res_status_next;
    logic signed [bvle_pkg::VALUE_W-1:0] res_value_reg, res_value_next;

    // result holding register
    logic                                out_valid_reg, out_valid_next;
    logic [bvle_pkg::STATUS_W-1:0]       out_status_reg, out_status_next;
    logic signed [bvle_pkg::VALUE_W-1:0] out_value_reg, out_value_next;
    logic [bvle_pkg::HELD_W-1:0]         out_held_reg, out_held_next;

    bvle_pkg::store_cmd_t                cmd;
    logic signed [bvle_pkg::VALUE_W-1:0] rd_data;
    logic                                match;
    logic [bvle_pkg::CNT_W-1:0]          last_idx;

    bvle_store u_store (
        .clk       (clk),
        .cmd       (cmd),
        .cmp_value (value_reg),
        .rd_data   (rd_data),
        .match     (match)
    );

    assign last_idx = count_reg - bvle_pkg::CNT_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bvle_pkg::S_IDLE;
            count_reg     <= '0;
            cmp_vld_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cmp_vld_reg   <= cmp_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        value_reg      <= value_next;
        idx_reg        <= idx_next;
        cmp_addr_reg   <= cmp_addr_next;
        hit_addr_reg   <= hit_addr_next;
        res_status_reg <= res_status_next;
        res_value_reg  <= res_value_next;
        out_status_reg <= out_status_next;
        out_value_reg  <= out_value_next;
        out_held_reg   <= out_held_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        value_next      = value_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        cmp_vld_next    = 1'b0;
        cmp_addr_next   = cmp_addr_reg;
        hit_addr_next   = hit_addr_reg;
        res_status_next = res_status_reg;
        res_value_next  = res_value_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_value_next  = out_value_reg;
        out_held_next   = out_held_reg;
        req.ready       = 1'b0;
        cmd             = '0;

        case (state_reg)
            bvle_pkg::S_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    op_next    = req.op;
                    value_next = req.value;
                    idx_next   = '0;
                    state_next = bvle_pkg::S_DISPATCH;
                end
            end

            bvle_pkg::S_DISPATCH:
            begin
                res_status_next = bvle_pkg::ST_DONE;
                res_value_next  = value_reg;
                state_next      = bvle_pkg::S_DONE;
                case (op_reg)
                    bvle_pkg::OP_INSERT:
                    begin
                        if (count_reg >= bvle_pkg::CNT_W'(bvle_pkg::CAPACITY))
                        begin
                            res_status_next = bvle_pkg::ST_FULL;
                        end
                        else
                        begin
                            // append at the packed tail
                            cmd.wr_en   = 1'b1;
                            cmd.wr_addr = count_reg[bvle_pkg::ADDR_W-1:0];
                            cmd.wr_data = value_reg;
                            count_next  = count_reg + bvle_pkg::CNT_W'(1);
                        end
                    end
                    bvle_pkg::OP_SEARCH:
                    begin
                        state_next = bvle_pkg::S_SCAN;
                    end
                    bvle_pkg::OP_DELETE:
                    begin
                        if (count_reg == '0)
                        begin
                            res_status_next = bvle_pkg::ST_EMPTY;
                            res_value_next  = bvle_pkg::NEG_ONE;
                        end
                        else
                        begin
                            state_next = bvle_pkg::S_SCAN;
                        end
                    end
                    default:
                    begin
                        state_next = bvle_pkg::S_DONE;
                    end
                endcase
            end

            // one read issued and one compare resolved per cycle
            bvle_pkg::S_SCAN:
            begin
                if (cmp_vld_reg && match)
                begin
                    res_status_next = bvle_pkg::ST_DONE;
                    res_value_next  = value_reg;
                    if (op_reg == bvle_pkg::OP_DELETE)
                    begin
                        if (cmp_addr_reg == last_idx[bvle_pkg::ADDR_W-1:0])
                        begin
                            count_next = last_idx;
                            state_next = bvle_pkg::S_DONE;
                        end
                        else
                        begin
                            // fetch tail entry to plug the hole
                            hit_addr_next = cmp_addr_reg;
                            cmd.rd_en     = 1'b1;
                            cmd.rd_addr   = last_idx[bvle_pkg::ADDR_W-1:0];
                            state_next    = bvle_pkg::S_MOVE;
                        end
                    end
                    else
                    begin
                        state_next = bvle_pkg::S_DONE;
                    end
                end
                else if (idx_reg != count_reg)
                begin
                    cmd.rd_en     = 1'b1;
                    cmd.rd_addr   = idx_reg[bvle_pkg::ADDR_W-1:0];
                    cmp_vld_next  = 1'b1;
                    cmp_addr_next = idx_reg[bvle_pkg::ADDR_W-1:0];
                    idx_next      = idx_reg + bvle_pkg::CNT_W'(1);
                end
                else if (!cmp_vld_reg)
                begin
                    res_status_next = bvle_pkg::ST_NOT_FOUND;
                    res_value_next  = (op_reg == bvle_pkg::OP_DELETE) ?
                                      bvle_pkg::NEG_ONE : value_reg;
                    state_next      = bvle_pkg::S_DONE;
                end
            end

            bvle_pkg::S_MOVE:
            begin
                cmd.wr_en   = 1'b1;
                cmd.wr_addr = hit_addr_reg;
                cmd.wr_data = rd_data;
                count_next  = last_idx;
                state_next  = bvle_pkg::S_DONE;
            end

            bvle_pkg::S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_value_next  = res_value_reg;
                    out_held_next   = bvle_pkg::HELD_W'(count_reg);
                    state_next      = bvle_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = bvle_pkg::S_IDLE;
            end
        endcase
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.result_value = out_value_reg;
    assign rsp.entries_held = out_held_reg;

endmodule

// ----- tb/bvle_checker.sv -----
module bvle_checker
    import bvle_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    bvle_req_if         req,
    bvle_rsp_if         rsp,
    output int unsigned mismatches,
    output int unsigned pending,
    output int unsigned answered,
    output int unsigned full_refusals,
    output int unsigned empty_deletes,
    output int unsigned peak_fill
);

    typedef struct packed {
        logic [STATUS_W-1:0]       status;
        logic signed [VALUE_W-1:0] result_value;
        logic [HELD_W-1:0]         entries_held;
    } list_rsp_t;

    // held values in insertion order, earliest first
    logic signed [VALUE_W-1:0] held_values[$];
    list_rsp_t                 expected_rsp[$];

    // Applies one request to the shadow list and returns its response.
    function automatic list_rsp_t apply_request(input logic [OP_W-1:0] op,
                                                input logic signed [VALUE_W-1:0] value);
        list_rsp_t r;
        int        hit;
        r.status       = ST_DONE;
        r.result_value = value;
        hit            = -1;
        for (int i = 0; i < held_values.size(); i++)
            if (hit < 0 && held_values[i] == value)
                hit = i;
        case (op)
            OP_INSERT:
            begin
                if (held_values.size() >= CAPACITY)
                begin
                    r.status = ST_FULL;
                    full_refusals++;
                end
                else
                    held_values.push_back(value);
            end
            OP_SEARCH:
            begin
                if (hit < 0)
                    r.status = ST_NOT_FOUND;
            end
            OP_DELETE:
            begin
                if (held_values.size() == 0)
                begin
                    r.status       = ST_EMPTY;
                    r.result_value = NEG_ONE;
                    empty_deletes++;
                end
                else if (hit < 0)
                begin
                    r.status       = ST_NOT_FOUND;
                    r.result_value = NEG_ONE;
                end
                else
                    held_values.delete(hit);
            end
            default: ;
        endcase
        r.entries_held = HELD_W'(held_values.size());
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        list_rsp_t want;
        list_rsp_t got;
        if (!rst_n)
        begin
            held_values.delete();
            expected_rsp.delete();
            mismatches    = 0;
            pending       = 0;
            answered      = 0;
            full_refusals = 0;
            empty_deletes = 0;
            peak_fill     = 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                got.status       = rsp.status;
                got.result_value = rsp.result_value;
                got.entries_held = rsp.entries_held;
                answered++;
                if (expected_rsp.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("%0t: unexpected response: status %0d value %0d held %0d",
                                 $time, got.status, got.result_value, got.entries_held);
                    mismatches++;
                end
                else
                begin
                    want = expected_rsp.pop_front();
                    if (got.status !== want.status ||
                        got.result_value !== want.result_value ||
                        got.entries_held !== want.entries_held)
                    begin
                        if (mismatches < 10)
                        begin
                            $write("%0t: response #%0d: expected status %0d value %0d held %0d,",
                                   $time, answered, want.status, want.result_value,
                                   want.entries_held);
                            $display(" got status %0d value %0d held %0d",
                                     got.status, got.result_value, got.entries_held);
                        end
                        mismatches++;
                    end
                end
            end
            if (req.valid && req.ready)
            begin
                expected_rsp.push_back(apply_request(req.op, req.value));
                if (held_values.size() > peak_fill)
                    peak_fill = held_values.size();
            end
            pending = expected_rsp.size();
        end
    end

endmodule

// ----- tb/tb_top.sv -----
module tb_top;
    import bvle_pkg::*;

    // op code 3 has no meaning in the block; it must echo and change nothing
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    localparam int RANDOM_ITEMS    = 1500;
    localparam int HOLD_OFF_AT     = 200;   // random request index where the receiver stops
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int STEADY_FROM     = 700;   // window with no idling on either side
    localparam int STEADY_TO       = 900;
    localparam int DRAIN_LIMIT     = 20000;
    localparam int SETTLE_CYCLES   = 100;   // longer than a full scan plus move

    // request mix of one random segment
    typedef enum logic [1:0] {
        MIX_FILL,
        MIX_BALANCED,
        MIX_DRAIN
    } load_mix_t;

    logic clk;
    logic rst_n;
    logic hold_off_go;
    logic steady_rsp;

    int unsigned mismatches;
    int unsigned pending;
    int unsigned answered;
    int unsigned full_refusals;
    int unsigned empty_deletes;
    int unsigned peak_fill;
    int unsigned sent;

    // wide random values that were issued, so later searches and deletes can hit them
    logic signed [VALUE_W-1:0] wide_values[$];

    bvle_req_if req_ch();
    bvle_rsp_if rsp_ch();

    bounded_value_list_engine u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source)
    );

    bvle_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .req           (req_ch),
        .rsp           (rsp_ch),
        .mismatches    (mismatches),
        .pending       (pending),
        .answered      (answered),
        .full_refusals (full_refusals),
        .empty_deletes (empty_deletes),
        .peak_fill     (peak_fill)
    );

    initial clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 0;
    end

    // Offers one request and returns at the edge where it is taken.
    // Valid only drops when a gap is actually inserted, so back-to-back
    // requests keep it high without a second assignment in the same step.
    task automatic send_request(input logic [OP_W-1:0] op,
                                input logic signed [VALUE_W-1:0] value,
                                input bit no_gaps);
        if (!no_gaps && $urandom_range(0, 99) < 32)
        begin
            req_ch.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < 32);
        end
        req_ch.valid <= 1'b1;
        req_ch.op    <= op;
        req_ch.value <= value;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        sent++;
    endtask

    // Mostly a handful of small values so duplicates pile up and deletes
    // hit; the rest are full-width values, some reused from earlier ones.
    function automatic logic signed [VALUE_W-1:0] pick_value();
        int unsigned roll;
        logic signed [VALUE_W-1:0] v;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            v = $signed(VALUE_W'($urandom_range(0, 7))) - 4;
        else if (roll < 85 && wide_values.size() != 0)
            v = wide_values[$urandom_range(0, wide_values.size() - 1)];
        else
        begin
            v = $urandom;
            wide_values.push_back(v);
            if (wide_values.size() > 8)
                void'(wide_values.pop_front());
        end
        return v;
    endfunction

    function automatic logic [OP_W-1:0] pick_op(input load_mix_t mix);
        int unsigned roll;
        logic [OP_W-1:0] op;
        roll = $urandom_range(0, 99);
        case (mix)
            MIX_FILL:
                op = (roll < 85) ? OP_INSERT : (roll < 93) ? OP_SEARCH :
                     (roll < 98) ? OP_DELETE : OP_UNUSED;
            MIX_DRAIN:
                op = (roll < 80) ? OP_DELETE : (roll < 92) ? OP_SEARCH :
                     (roll < 97) ? OP_INSERT : OP_UNUSED;
            default:
                op = (roll < 40) ? OP_INSERT : (roll < 65) ? OP_SEARCH :
                     (roll < 95) ? OP_DELETE : OP_UNUSED;
        endcase
        return op;
    endfunction

    // Response side: random back-pressure, one long hold-off while the
    // sender keeps offering, and a steady window with ready held high.
    initial
    begin : rsp_side
        bit hold_done;
        hold_done    = 1'b0;
        rsp_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_off_go && !hold_done)
            begin
                hold_done = 1'b1;
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            rsp_ch.ready <= steady_rsp || ($urandom_range(0, 99) >= 32);
        end
    end

    // Stimulus and verdict
    initial
    begin : stimulus
        int        seg_left;
        int        seg_index;
        int        waited;
        bit        no_gaps;
        load_mix_t mix;

        rst_n        = 1'b0;
        hold_off_go  <= 1'b0;
        steady_rsp   <= 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.op    <= OP_INSERT;
        req_ch.value <= '0;
        sent         = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty-store corners, field extremes, duplicates, absent values.
        send_request(OP_DELETE, 32'sd5, 1'b0);            // delete from empty store
        send_request(OP_SEARCH, 32'sh8000_0000, 1'b0);    // search of empty store
        send_request(OP_UNUSED, 32'sh7FFF_FFFF, 1'b0);    // unused op on empty store
        send_request(OP_INSERT, 32'sh7FFF_FFFF, 1'b0);
        send_request(OP_INSERT, 32'sh8000_0000, 1'b0);
        send_request(OP_INSERT, 32'sd0, 1'b0);
        send_request(OP_INSERT, -32'sd1, 1'b0);
        send_request(OP_INSERT, 32'sd0, 1'b0);            // duplicate
        send_request(OP_SEARCH, 32'sh7FFF_FFFF, 1'b0);
        send_request(OP_SEARCH, 32'sd12345, 1'b0);        // absent
        send_request(OP_DELETE, 32'sd0, 1'b0);            // earliest of the duplicates
        send_request(OP_SEARCH, 32'sd0, 1'b0);            // later copy still held
        send_request(OP_DELETE, 32'sd777, 1'b0);          // absent value
        send_request(OP_DELETE, -32'sd1, 1'b0);           // removed value looks like failure code
        send_request(OP_UNUSED, 32'sh5555_AAAA, 1'b0);    // unused op with entries held
        send_request(OP_DELETE, 32'sh8000_0000, 1'b0);
        send_request(OP_DELETE, 32'sd0, 1'b0);
        send_request(OP_DELETE, 32'sh7FFF_FFFF, 1'b0);    // store empty again
        send_request(OP_DELETE, 32'sd0, 1'b0);

        // Random: segments cycle fill, balanced, drain, drain so the store
        // swings between full (and refuses inserts) and nearly empty.
        seg_left  = 0;
        seg_index = -1;
        mix       = MIX_FILL;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (seg_left == 0)
            begin
                seg_index++;
                seg_left = $urandom_range(90, 150);
                case (seg_index % 4)
                    0:       mix = MIX_FILL;
                    1:       mix = MIX_BALANCED;
                    default: mix = MIX_DRAIN;
                endcase
            end
            seg_left--;
            if (n == HOLD_OFF_AT)
                hold_off_go <= 1'b1;
            if (n == STEADY_FROM)
                steady_rsp <= 1'b1;
            if (n == STEADY_TO)
                steady_rsp <= 1'b0;
            // keep offering through the hold-off so the input backs up
            no_gaps = (n >= HOLD_OFF_AT && n < HOLD_OFF_AT + 60) ||
                      (n >= STEADY_FROM && n < STEADY_TO);
            send_request(pick_op(mix), pick_value(), no_gaps);
        end
        req_ch.valid <= 1'b0;

        // Drain outstanding responses, then let any scan in flight finish.
        @(posedge clk);
        waited = 0;
        while (pending != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("%0d requests sent, %0d responses checked; peak fill %0d of %0d",
                 sent, answered, peak_fill, CAPACITY);
        $display("%0d inserts refused as full, %0d deletes on an empty store, %0d mismatches",
                 full_refusals, empty_deletes, mismatches);
        if (mismatches == 0 && pending == 0)
            $display("[bounded_value_list_engine] OK");
        else
            $display("[bounded_value_list_engine] ERROR");
        $finish;
    end

    // Hang guard: several times the slowest legal run.
    initial
    begin : watchdog
        #8_000_000;
        $display("[bounded_value_list_engine] ERROR");
        $finish;
    end

endmodule
